>>> hdl/anchored_rect_chain_resolver_defines.svh
// Assertion macros shared by the region chain resolver RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including module.
`ifndef ANCHORED_RECT_CHAIN_RESOLVER_DEFINES_SVH
`define ANCHORED_RECT_CHAIN_RESOLVER_DEFINES_SVH

`ifndef SYNTHESIS
`define ARCR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ARCR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ARCR_ASSERT_IMPL(name, ante, cons)
`define ARCR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> hdl/arcr_pkg.sv
// Shared types and constants of the region chain resolver.
// No dependencies.
package arcr_pkg;

    localparam logic MODE_WRITE = 1'b0;

    localparam logic [7:0] TYPE_TL   = 8'd1;
    localparam logic [7:0] TYPE_BR   = 8'd2;
    localparam logic [7:0] TYPE_TR   = 8'd3;
    localparam logic [7:0] TYPE_BL   = 8'd4;
    localparam logic [7:0] TYPE_SIZE = 8'd9;
    localparam logic [7:0] TYPE_PASS = 8'd10;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNKNOWN     = 3'd1,
        ST_CYCLE       = 3'd2,
        ST_BAD_PARENT  = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } arcr_status_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  anchor;
        logic [7:0]  parent;
        logic [15:0] off_a;
        logic [15:0] off_b;
    } arcr_entry_t;

    typedef struct packed {
        arcr_status_t status;
        logic         has_rect;
        logic [15:0]  left_x;
        logic [15:0]  top_y;
        logic [15:0]  width;
        logic [15:0]  height;
    } arcr_result_t;

    function automatic arcr_result_t err_result(input arcr_status_t code);
        arcr_result_t res;
        res = '0;
        res.status = code;
        return res;
    endfunction

endpackage

>>> hdl/arcr_table.sv
// Region record memory: one write port and one read port with registered read data.
// Depends on arcr_pkg.
module arcr_table #(
    parameter int TABLE_ENTRIES = 256,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                  clk,
    input  logic                  mem_we,
    input  logic [IDX_W-1:0]      mem_waddr,
    input  arcr_pkg::arcr_entry_t mem_wdata,
    input  logic                  mem_re,
    input  logic [IDX_W-1:0]      mem_raddr,
    output arcr_pkg::arcr_entry_t rd_data
);
    import arcr_pkg::*;

    arcr_entry_t mem [TABLE_ENTRIES];
    arcr_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/arcr_walk.sv
// Control of the resolver: table clearing, record writes and the upward parent walk.
// Depends on arcr_pkg and drives the record memory in arcr_table.
`include "anchored_rect_chain_resolver_defines.svh"

module arcr_walk #(
    parameter int TABLE_ENTRIES = 256,
    parameter int WALK_LIMIT = 32,
    localparam int IDX_W = $clog2(TABLE_ENTRIES),
    localparam int STEP_W = $clog2(WALK_LIMIT + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [7:0]             node_id,
    input  logic [7:0]             anchor_type,
    input  logic [7:0]             parent_id,
    input  logic signed [15:0]     offset_a,
    input  logic signed [15:0]     offset_b,
    output logic                   mem_we,
    output logic [IDX_W-1:0]       mem_waddr,
    output arcr_pkg::arcr_entry_t  mem_wdata,
    output logic                   mem_re,
    output logic [IDX_W-1:0]       mem_raddr,
    input  arcr_pkg::arcr_entry_t  rd_data,
    output logic                   res_valid,
    input  logic                   res_take,
    output arcr_pkg::arcr_result_t res
);
    import arcr_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WALK  = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } walk_state_t;

    walk_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [STEP_W-1:0]  steps_dec;
    logic [STEP_W-1:0]  nx_reg, nx_next;
    logic [STEP_W-1:0]  ny_reg, ny_next;
    logic [15:0]        sum_a_reg, sum_a_next;
    logic [15:0]        sum_b_reg, sum_b_next;
    logic [15:0]        w_reg, w_next;
    logic [15:0]        h_reg, h_next;
    logic [15:0]        prod_x, prod_y;
    arcr_result_t       res_reg, res_next;

    function automatic logic id_ok(input logic [7:0] id);
        return int'(id) < TABLE_ENTRIES;
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign steps_dec = steps_reg - STEP_W'(1);

    // Type 2/3 records move the left edge by one minus the width; 2/4 likewise in y.
    assign prod_x = 16'(nx_reg) * (16'd1 - w_reg);
    assign prod_y = 16'(ny_reg) * (16'd1 - h_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        steps_next   = steps_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_cnt_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = IDX_W'(node_id);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        mem_we           = id_ok(node_id);
                        mem_waddr        = IDX_W'(node_id);
                        mem_wdata.valid  = 1'b1;
                        mem_wdata.anchor = anchor_type;
                        mem_wdata.parent = parent_id;
                        mem_wdata.off_a  = offset_a;
                        mem_wdata.off_b  = offset_b;
                        res_next         = err_result(ST_OK);
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        steps_next = STEP_W'(WALK_LIMIT);
                        nx_next    = '0;
                        ny_next    = '0;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        if (!id_ok(node_id))
                        begin
                            res_next   = err_result(ST_UNKNOWN);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_WALK:
            begin
                mem_raddr = IDX_W'(rd_data.parent);
                if (!rd_data.valid)
                begin
                    res_next   = err_result(ST_UNKNOWN);
                    state_next = S_DONE;
                end
                else
                begin
                    steps_next = steps_dec;
                    case (rd_data.anchor)
                        TYPE_SIZE:
                        begin
                            w_next     = rd_data.off_a;
                            h_next     = rd_data.off_b;
                            state_next = S_PLACE;
                        end
                        TYPE_TL, TYPE_BR, TYPE_TR, TYPE_BL, TYPE_PASS:
                        begin
                            if (rd_data.anchor != TYPE_PASS)
                            begin
                                sum_a_next = sum_a_reg + rd_data.off_a;
                                sum_b_next = sum_b_reg + rd_data.off_b;
                                if (rd_data.anchor == TYPE_BR || rd_data.anchor == TYPE_TR)
                                begin
                                    nx_next = nx_reg + STEP_W'(1);
                                end
                                if (rd_data.anchor == TYPE_BR || rd_data.anchor == TYPE_BL)
                                begin
                                    ny_next = ny_reg + STEP_W'(1);
                                end
                            end
                            if (rd_data.parent == 8'd0)
                            begin
                                res_next   = err_result(ST_BAD_PARENT);
                                state_next = S_DONE;
                            end
                            else if (steps_dec == '0)
                            begin
                                res_next   = err_result(ST_CYCLE);
                                state_next = S_DONE;
                            end
                            else if (!id_ok(rd_data.parent))
                            begin
                                res_next   = err_result(ST_UNKNOWN);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next   = err_result(ST_UNSUPPORTED);
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PLACE:
            begin
                res_next.status   = ST_OK;
                res_next.has_rect = 1'b1;
                res_next.left_x   = sum_a_reg + prod_x;
                res_next.top_y    = sum_b_reg + prod_y;
                res_next.width    = w_reg;
                res_next.height   = h_reg;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            steps_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            steps_reg   <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        sum_a_reg <= sum_a_next;
        sum_b_reg <= sum_b_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        res_reg   <= res_next;
    end

    `ARCR_ASSERT_IMPL(a_walk_has_steps, state_reg == S_WALK, steps_reg != '0)
    `ARCR_ASSERT_IMPL(a_no_read_on_write, mem_we, !mem_re)
    `ARCR_ASSERT_NEXT(a_result_holds, res_valid && !res_take, res_valid && $stable(res_reg))
    `ARCR_ASSERT_NEXT(a_place_ok, state_reg == S_PLACE, res_reg.status == ST_OK && res_reg.has_rect)

endmodule

>>> hdl/anchored_rect_chain_resolver.sv
// A write item is answered from the walk's result register without a table walk; a resolve
// item walks n lookups up to a size record and then places the rectangle (S_PLACE), or stops
// at the first error. The walk is capped at WALK_LIMIT lookups.
// Throughput: one table lookup per cycle while walking; the next item is accepted only once the
// previous result has moved into the output register. After reset a clearing pass over all
// TABLE_ENTRIES records runs before the first item is accepted.
// Top level of the region chain resolver: record memory, walk control and output register.
// Depends on arcr_pkg, arcr_table and arcr_walk.
`include "anchored_rect_chain_resolver_defines.svh"

module anchored_rect_chain_resolver #(
    parameter int TABLE_ENTRIES = 256,
    parameter int WALK_LIMIT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [7:0]         node_id,
    input  logic [7:0]         anchor_type,
    input  logic [7:0]         parent_id,
    input  logic signed [15:0] offset_a,
    input  logic signed [15:0] offset_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [15:0] left_x,
    output logic signed [15:0] top_y,
    output logic signed [15:0] right_x,
    output logic signed [15:0] bottom_y,
    output logic signed [15:0] rect_width,
    output logic signed [15:0] rect_height
);
    import arcr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    arcr_entry_t      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    arcr_entry_t      rd_data;
    logic             res_valid;
    logic             res_take;
    arcr_result_t     res;

    logic             out_valid_reg, out_valid_next;
    arcr_status_t     out_status_reg;
    logic [15:0]      out_left_reg, out_top_reg, out_right_reg, out_bottom_reg;
    logic [15:0]      out_width_reg, out_height_reg;
    logic             out_rect_zero;

    arcr_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .clk      (clk),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .rd_data  (rd_data)
    );

    arcr_walk #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .WALK_LIMIT   (WALK_LIMIT)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .node_id    (node_id),
        .anchor_type(anchor_type),
        .parent_id  (parent_id),
        .offset_a   (offset_a),
        .offset_b   (offset_b),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Corners follow from the top-left corner and the size; records without a rectangle read zero.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_status_reg <= res.status;
            if (res.has_rect)
            begin
                out_left_reg   <= res.left_x;
                out_top_reg    <= res.top_y;
                out_right_reg  <= res.left_x + res.width - 16'd1;
                out_bottom_reg <= res.top_y + res.height - 16'd1;
                out_width_reg  <= res.width;
                out_height_reg <= res.height;
            end
            else
            begin
                out_left_reg   <= '0;
                out_top_reg    <= '0;
                out_right_reg  <= '0;
                out_bottom_reg <= '0;
                out_width_reg  <= '0;
                out_height_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign left_x      = out_left_reg;
    assign top_y       = out_top_reg;
    assign right_x     = out_right_reg;
    assign bottom_y    = out_bottom_reg;
    assign rect_width  = out_width_reg;
    assign rect_height = out_height_reg;

    assign out_rect_zero = ({left_x, top_y, right_x, bottom_y, rect_width, rect_height} == '0);

    `ARCR_ASSERT_IMPL(a_error_zero, out_valid && status != ST_OK, out_rect_zero)
    `ARCR_ASSERT_IMPL(a_status_range, out_valid, status <= ST_UNSUPPORTED)
    `ARCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_x))

endmodule

>>> sim/anchored_rect_chain_checker.sv
// Checker for the region chain resolver: keeps its own copy of the region table,
// predicts each result at input acceptance and compares accepted results in order.
// Depends on arcr_pkg for the status codes and record type constants.
`timescale 1ns / 1ps

module anchored_rect_chain_checker #(
    parameter int WALK_LIMIT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               mode,
    input  logic [7:0]         node_id,
    input  logic [7:0]         anchor_type,
    input  logic [7:0]         parent_id,
    input  logic signed [15:0] offset_a,
    input  logic signed [15:0] offset_b,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         status,
    input  logic signed [15:0] left_x,
    input  logic signed [15:0] top_y,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] bottom_y,
    input  logic signed [15:0] rect_width,
    input  logic signed [15:0] rect_height,
    output int unsigned        fail_count,
    output int unsigned        pending_count
);

    import arcr_pkg::*;

    localparam int TABLE_SIZE = 256;

    typedef struct packed {
        arcr_status_t status;
        logic [15:0]  left_x;
        logic [15:0]  top_y;
        logic [15:0]  right_x;
        logic [15:0]  bottom_y;
        logic [15:0]  width;
        logic [15:0]  height;
    } rect_answer_t;

    logic         rec_valid  [TABLE_SIZE];
    logic [7:0]   rec_anchor [TABLE_SIZE];
    logic [7:0]   rec_parent [TABLE_SIZE];
    logic [15:0]  rec_a      [TABLE_SIZE];
    logic [15:0]  rec_b      [TABLE_SIZE];
    rect_answer_t pending_rects [$];
    rect_answer_t want;

    function automatic rect_answer_t resolve_rect(input logic [7:0] rid);
        rect_answer_t r;
        logic [7:0]   links [$];
        logic [7:0]   node;
        logic [7:0]   kind;
        logic [15:0]  w, h, ax, ay, x1, y1, x2, y2;
        int           steps;
        logic         found;
        r = '0;
        node = rid;
        steps = WALK_LIMIT;
        found = 1'b0;
        while (!found) begin
            if (steps == 0) begin
                r.status = ST_CYCLE;
                return r;
            end
            if (!rec_valid[node]) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            steps--;
            kind = rec_anchor[node];
            if (kind == TYPE_SIZE) begin
                found = 1'b1;
            end else if (kind == TYPE_PASS || (kind >= TYPE_TL && kind <= TYPE_BL)) begin
                if (rec_parent[node] == 8'd0) begin
                    r.status = ST_BAD_PARENT;
                    return r;
                end
                if (kind != TYPE_PASS) begin
                    links.push_back(node);
                end
                node = rec_parent[node];
            end else begin
                r.status = ST_UNSUPPORTED;
                return r;
            end
        end
        w = rec_a[node];
        h = rec_b[node];
        x1 = 16'd0;
        y1 = 16'd0;
        x2 = w - 16'd1;
        y2 = h - 16'd1;
        while (links.size() > 0) begin
            node = links.pop_back();
            ax = x1 + rec_a[node];
            ay = y1 + rec_b[node];
            case (rec_anchor[node])
                TYPE_TL:
                begin
                    x1 = ax;
                    y1 = ay;
                    x2 = ax + w - 16'd1;
                    y2 = ay + h - 16'd1;
                end
                TYPE_BR:
                begin
                    x2 = ax;
                    y2 = ay;
                    x1 = ax - w + 16'd1;
                    y1 = ay - h + 16'd1;
                end
                TYPE_TR:
                begin
                    x2 = ax;
                    y1 = ay;
                    x1 = ax - w + 16'd1;
                    y2 = ay + h - 16'd1;
                end
                default:
                begin
                    x1 = ax;
                    y2 = ay;
                    x2 = ax + w - 16'd1;
                    y1 = ay - h + 16'd1;
                end
            endcase
        end
        r.status = ST_OK;
        r.left_x = x1;
        r.top_y = y1;
        r.right_x = x2;
        r.bottom_y = y2;
        r.width = x2 - x1 + 16'd1;
        r.height = y2 - y1 + 16'd1;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch in %s: expected %h, got %h", name, exp_val, got_val);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                rec_valid[i] = 1'b0;
            end
            pending_rects.delete();
            pending_count = 0;
            fail_count = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_rects.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result with none pending: status %0d", status);
                    end
                end else begin
                    want = pending_rects.pop_front();
                    compare_field("status", 16'(want.status), 16'(status));
                    compare_field("left_x", want.left_x, left_x);
                    compare_field("top_y", want.top_y, top_y);
                    compare_field("right_x", want.right_x, right_x);
                    compare_field("bottom_y", want.bottom_y, bottom_y);
                    compare_field("rect_width", want.width, rect_width);
                    compare_field("rect_height", want.height, rect_height);
                end
            end
            if (in_valid && !in_stall) begin
                if (mode == MODE_WRITE) begin
                    rec_valid[node_id] = 1'b1;
                    rec_anchor[node_id] = anchor_type;
                    rec_parent[node_id] = parent_id;
                    rec_a[node_id] = offset_a;
                    rec_b[node_id] = offset_b;
                    want = '0;
                    want.status = ST_OK;
                    pending_rects.push_back(want);
                end else begin
                    pending_rects.push_back(resolve_rect(node_id));
                end
            end
            pending_count = pending_rects.size();
        end
    end

endmodule

>>> sim/tb_anchored_rect_chain_resolver.sv
// Testbench top for the region chain resolver: drives record writes and chain resolves
// with random gaps and output stalls, and gives the verdict from the checker's counts.
// Depends on arcr_pkg, anchored_rect_chain_resolver and anchored_rect_chain_checker.
`timescale 1ns / 1ps

module tb_anchored_rect_chain_resolver;

    import arcr_pkg::*;

    localparam int   WALK_LIMIT = 32;
    localparam int   RANDOM_ITEMS = 1300;
    localparam int   CYCLE_LIMIT = 600000;
    localparam logic MODE_RESOLVE = ~MODE_WRITE;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [7:0]         node_id;
    logic [7:0]         anchor_type;
    logic [7:0]         parent_id;
    logic signed [15:0] offset_a;
    logic signed [15:0] offset_b;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] right_x;
    logic signed [15:0] bottom_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    int unsigned        fail_count;
    int unsigned        pending_count;

    int unsigned gap_max = 15;
    int unsigned stall_max = 15;
    int unsigned rx_hold_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    anchored_rect_chain_resolver #(
        .WALK_LIMIT(WALK_LIMIT)
    ) u_dut (.*);

    anchored_rect_chain_checker #(
        .WALK_LIMIT(WALK_LIMIT)
    ) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : receiver
        int unsigned hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles != 0)
            begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                hold = $urandom_range(0, stall_max);
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    task automatic offer_item(input logic m, input logic [7:0] node, input logic [7:0] kind,
                              input logic [7:0] par, input logic [15:0] a,
                              input logic [15:0] b);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        node_id <= node;
        anchor_type <= kind;
        parent_id <= par;
        offset_a <= a;
        offset_b <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_record(input logic [7:0] node, input logic [7:0] kind,
                                input logic [7:0] par, input logic [15:0] a,
                                input logic [15:0] b);
        offer_item(MODE_WRITE, node, kind, par, a, b);
    endtask

    task automatic resolve_region(input logic [7:0] node);
        offer_item(MODE_RESOLVE, node, 8'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_link_type();
        case ($urandom_range(0, 4))
            0: return TYPE_TL;
            1: return TYPE_BR;
            2: return TYPE_TR;
            3: return TYPE_BL;
            default: return TYPE_PASS;
        endcase
    endfunction

    task automatic chain_and_resolve(input int links);
        logic [7:0] chain [$];
        logic [7:0] node;
        node = 8'($urandom_range(1, 255));
        chain.push_back(node);
        write_record(node, TYPE_SIZE, 8'($urandom), 16'($urandom), 16'($urandom));
        for (int k = 0; k < links; k++)
        begin
            node = (k == links - 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255));
            write_record(node, pick_link_type(), chain[chain.size() - 1], 16'($urandom),
                         16'($urandom));
            chain.push_back(node);
        end
        resolve_region(node);
        if ($urandom_range(0, 2) == 0)
        begin
            resolve_region(chain[$urandom_range(0, chain.size() - 1)]);
        end
    endtask

    task automatic broken_record();
        logic [7:0] node;
        node = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 2))
            0: write_record(node, pick_link_type(), 8'd0, 16'($urandom), 16'($urandom));
            1: write_record(node, 8'($urandom_range(11, 255)), 8'($urandom), 16'($urandom),
                            16'($urandom));
            default: write_record(node, TYPE_PASS, node, 16'($urandom), 16'($urandom));
        endcase
        resolve_region(node);
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned phase_end;
        int unsigned random_end;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_WRITE;
        node_id = '0;
        anchor_type = '0;
        parent_id = '0;
        offset_a = '0;
        offset_b = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_record(8'd1, TYPE_SIZE, 8'hA5, 16'sd100, 16'sd50);
        resolve_region(8'd1);
        write_record(8'd0, TYPE_TL, 8'd1, 16'sd10, 16'sd20);
        resolve_region(8'd0);
        write_record(8'd2, TYPE_BR, 8'd1, 16'sh7FFF, 16'sh8000);
        resolve_region(8'd2);
        write_record(8'd3, TYPE_TR, 8'd2, -16'sd1, -16'sd1);
        resolve_region(8'd3);
        write_record(8'd4, TYPE_BL, 8'd3, 16'sh8000, 16'sh7FFF);
        resolve_region(8'd4);
        write_record(8'd5, TYPE_PASS, 8'd4, 16'sd0, 16'sd0);
        resolve_region(8'd5);
        write_record(8'd6, TYPE_PASS, 8'd0, 16'sd3, 16'sd4);
        resolve_region(8'd6);
        write_record(8'd7, 8'd0, 8'd1, 16'sd1, 16'sd1);
        resolve_region(8'd7);
        resolve_region(8'd200);
        write_record(8'd8, TYPE_PASS, 8'd8, 16'sd0, 16'sd0);
        resolve_region(8'd8);
        write_record(8'd255, TYPE_SIZE, 8'hFF, 16'sd0, 16'sh8000);
        resolve_region(8'd255);

        random_end = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_end)
        begin
            case (phase % 5)
                0:
                begin
                    gap_max = 15;
                    stall_max = 15;
                end
                1:
                begin
                    gap_max = 0;
                    stall_max = 0;
                end
                2:
                begin
                    gap_max = 15;
                    stall_max = 0;
                end
                3:
                begin
                    gap_max = 0;
                    stall_max = 15;
                end
                default:
                begin
                    gap_max = $urandom_range(0, 15);
                    stall_max = $urandom_range(0, 15);
                end
            endcase
            if (phase == 3)
            begin
                rx_hold_cycles = 300;
            end
            if (phase == 6)
            begin
                wait_drain();
            end
            phase_end = items_sent + 130;
            while (items_sent < phase_end && items_sent < random_end)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6:
                    begin
                        if ($urandom_range(0, 11) == 0)
                        begin
                            chain_and_resolve($urandom_range(28, 34));
                        end
                        else
                        begin
                            chain_and_resolve($urandom_range(0, 6));
                        end
                    end
                    7: write_record(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                                    16'($urandom));
                    8: resolve_region(8'($urandom));
                    default: broken_record();
                endcase
            end
            phase++;
        end

        wait_drain();
        repeat (WALK_LIMIT + 8) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
